// File: rtl/rbsi_pkg.sv
package rbsi_pkg;

	localparam int COORD_W       = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int DIST_W        = 31;
	localparam int AXES          = 3;
	localparam int REG_IDX_W     = 3;

	localparam logic [DIST_W-1:0] TMAX = '1;

	localparam logic [REG_IDX_W-1:0] REG_LOWER_X = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LOWER_Y = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_LOWER_Z = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_UPPER_X = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_UPPER_Y = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_UPPER_Z = 3'd5;

	// divider: one overflow check stage, then one quotient bit per stage
	localparam int DIV_LAT  = DIST_W + 1;
	localparam int LANE_LAT = DIV_LAT + 2;
	localparam int CORE_LAT = LANE_LAT + 1;

	typedef struct packed {
		logic signed [COORD_W-1:0] origin_x;
		logic signed [COORD_W-1:0] origin_y;
		logic signed [COORD_W-1:0] origin_z;
		logic signed [COORD_W-1:0] dir_x;
		logic signed [COORD_W-1:0] dir_y;
		logic signed [COORD_W-1:0] dir_z;
	} ray_t;

	typedef struct packed {
		logic              hit;
		logic              origin_inside;
		logic [DIST_W-1:0] near_dist;
		logic [DIST_W-1:0] far_dist;
	} result_t;

	typedef struct packed {
		logic               dzero;
		logic               in_slab;
		logic signed [DIST_W:0] lo;
		logic signed [DIST_W:0] hi;
	} slab_t;

endpackage

// File: rtl/rbsi_div.sv
module rbsi_div #(
	parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic [rbsi_pkg::COORD_W:0]     num_mag,
	input  logic [rbsi_pkg::COORD_W-1:0]   den_mag,
	input  logic                           neg,
	output logic signed [rbsi_pkg::DIST_W:0] t_out
);
	import rbsi_pkg::*;

	localparam int NW = COORD_W + 1 + FRAC_BITS;
	localparam int WW = NW + DIST_W;

	logic [NW-1:0]      rem_q [DIV_LAT];
	logic [DIST_W-1:0]  quo_q [DIV_LAT];
	logic [COORD_W-1:0] den_q [DIV_LAT];
	logic               neg_q [DIV_LAT];
	logic               ov_q  [DIV_LAT];

	logic [NW-1:0]     num0;
	logic              ov0;
	logic [DIST_W-1:0] mag;

	assign num0 = NW'(num_mag) << FRAC_BITS;
	// quotient of 2^DIST_W or more saturates
	assign ov0  = WW'(num0) >= (WW'(den_mag) << DIST_W);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= num0;
			quo_q[0] <= '0;
			den_q[0] <= den_mag;
			neg_q[0] <= neg;
			ov_q[0]  <= ov0;
		end
	end

	for (genvar p = 1; p < DIV_LAT; p++) begin : g_bit
		localparam int K = DIST_W - p;
		logic [WW-1:0]     sub;
		logic [WW-1:0]     diff;
		logic              ge;
		logic [DIST_W-1:0] nq;

		always_comb begin
			sub   = WW'(den_q[p-1]) << K;
			ge    = WW'(rem_q[p-1]) >= sub;
			diff  = WW'(rem_q[p-1]) - sub;
			nq    = quo_q[p-1];
			nq[K] = ge;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[p] <= ge ? diff[NW-1:0] : rem_q[p-1];
				quo_q[p] <= nq;
				den_q[p] <= den_q[p-1];
				neg_q[p] <= neg_q[p-1];
				ov_q[p]  <= ov_q[p-1];
			end
		end
	end

	assign mag   = ov_q[DIV_LAT-1] ? TMAX : quo_q[DIV_LAT-1];
	assign t_out = neg_q[DIV_LAT-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

// File: rtl/rbsi_lane.sv
module rbsi_lane #(
	parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [rbsi_pkg::COORD_W-1:0] lower,
	input  logic signed [rbsi_pkg::COORD_W-1:0] upper,
	input  logic signed [rbsi_pkg::COORD_W-1:0] origin,
	input  logic signed [rbsi_pkg::COORD_W-1:0] dir,
	output rbsi_pkg::slab_t                    slab
);
	import rbsi_pkg::*;

	logic signed [COORD_W:0] dl, du;
	logic [COORD_W:0]        ml_s1, mu_s1;
	logic [COORD_W-1:0]      md_s1;
	logic                    nl_s1, nu_s1;
	logic                    within_s1, dzero_s1;
	logic                    within_q [DIV_LAT];
	logic                    dzero_q  [DIV_LAT];
	logic signed [DIST_W:0]  ta, tb;

	assign dl = $signed({lower[COORD_W-1], lower}) - $signed({origin[COORD_W-1], origin});
	assign du = $signed({upper[COORD_W-1], upper}) - $signed({origin[COORD_W-1], origin});

	always_ff @(posedge clk) begin
		if (en) begin
			ml_s1     <= dl[COORD_W] ? COORD_W'(0) - dl : dl;
			mu_s1     <= du[COORD_W] ? COORD_W'(0) - du : du;
			md_s1     <= dir[COORD_W-1] ? COORD_W'(0) - dir : dir;
			nl_s1     <= dl[COORD_W] ^ dir[COORD_W-1];
			nu_s1     <= du[COORD_W] ^ dir[COORD_W-1];
			within_s1 <= (lower <= origin) && (origin <= upper);
			dzero_s1  <= (dir == '0);
		end
	end

	rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
		.clk(clk), .en(en), .num_mag(ml_s1), .den_mag(md_s1), .neg(nl_s1), .t_out(ta)
	);
	rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
		.clk(clk), .en(en), .num_mag(mu_s1), .den_mag(md_s1), .neg(nu_s1), .t_out(tb)
	);

	// carry axis flags alongside the divider stages
	always_ff @(posedge clk) begin
		if (en) begin
			within_q[0] <= within_s1;
			dzero_q[0]  <= dzero_s1;
			for (int i = 1; i < DIV_LAT; i++) begin
				within_q[i] <= within_q[i-1];
				dzero_q[i]  <= dzero_q[i-1];
			end
			slab.in_slab <= within_q[DIV_LAT-1];
			slab.dzero   <= dzero_q[DIV_LAT-1];
			slab.lo      <= (ta > tb) ? tb : ta;
			slab.hi      <= (ta > tb) ? ta : tb;
		end
	end

endmodule

// File: rtl/rbsi_merge.sv
module rbsi_merge (
	input  logic              clk,
	input  logic              en,
	input  rbsi_pkg::slab_t   slab [rbsi_pkg::AXES],
	output rbsi_pkg::result_t res
);
	import rbsi_pkg::*;

	logic signed [DIST_W:0] tmin, tmax;
	logic                   hit, org_in;

	always_comb begin
		tmin   = '0;
		tmax   = $signed({1'b0, TMAX});
		hit    = 1'b1;
		org_in = 1'b1;
		for (int i = 0; i < AXES; i++) begin
			if (!slab[i].in_slab) org_in = 1'b0;
			if (slab[i].dzero) begin
				if (!slab[i].in_slab) hit = 1'b0;
			end else begin
				if (slab[i].lo > tmin) tmin = slab[i].lo;
				if (slab[i].hi < tmax) tmax = slab[i].hi;
				if (tmin > tmax) hit = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res.hit           <= hit;
			res.origin_inside <= hit && org_in;
			if (!hit) begin
				res.near_dist <= '0;
				res.far_dist  <= '0;
			end else if (org_in) begin
				res.near_dist <= tmax[DIST_W-1:0];
				res.far_dist  <= TMAX;
			end else begin
				res.near_dist <= tmin[DIST_W-1:0];
				res.far_dist  <= tmax[DIST_W-1:0];
			end
		end
	end

endmodule

// File: rtl/ray_box_slab_intersect_core.sv
// Ray versus axis-aligned box, slab method, signed fixed point.
// Input channel in_valid / in_stall / in_word carries one ray word: origin
// and direction per axis. Output channel out_valid / out_stall / out_word
// carries hit, origin_inside, near_dist and far_dist for that ray.
// Box corners live in six registers written through wr_en / wr_idx /
// wr_data; write them only while no ray is in flight.
// Pipeline: 35 register stages (one input stage, 32 divider stages: an
// overflow check then one quotient bit each, an ordering stage, the merge
// register).
// Throughput: one ray per cycle unless the output stalls, set by the fully
// pipelined dividers, two per axis lane, three lanes side by side.
// An output stall with out_valid high freezes the whole pipe and holds
// out_word; in_stall rises in the same cycle, so no word is lost or repeated.
// Reset clears the box corners to zero and empties the pipe.
module ray_box_slab_intersect_core #(
	parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [rbsi_pkg::REG_IDX_W-1:0]    wr_idx,
	input  logic [rbsi_pkg::COORD_W-1:0]      wr_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  rbsi_pkg::ray_t                    in_word,
	output logic                              out_valid,
	input  logic                              out_stall,
	output rbsi_pkg::result_t                 out_word
);
	import rbsi_pkg::*;

	logic signed [COORD_W-1:0] lower_q [AXES];
	logic signed [COORD_W-1:0] upper_q [AXES];
	logic signed [COORD_W-1:0] org    [AXES];
	logic signed [COORD_W-1:0] dir    [AXES];
	logic                      vld_q  [CORE_LAT];
	slab_t                     slab   [AXES];
	logic                      en;

	// advance the pipe unless a finished word is held
	assign en        = !(vld_q[CORE_LAT-1] && out_stall);
	assign in_stall  = !en;
	assign out_valid = vld_q[CORE_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				lower_q[i] <= '0;
				upper_q[i] <= '0;
			end
		end else if (wr_en) begin
			unique case (wr_idx)
				REG_LOWER_X: lower_q[0] <= wr_data;
				REG_LOWER_Y: lower_q[1] <= wr_data;
				REG_LOWER_Z: lower_q[2] <= wr_data;
				REG_UPPER_X: upper_q[0] <= wr_data;
				REG_UPPER_Y: upper_q[1] <= wr_data;
				REG_UPPER_Z: upper_q[2] <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CORE_LAT; i++) vld_q[i] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_valid;
			for (int i = 1; i < CORE_LAT; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	assign org[0] = in_word.origin_x;
	assign org[1] = in_word.origin_y;
	assign org[2] = in_word.origin_z;
	assign dir[0] = in_word.dir_x;
	assign dir[1] = in_word.dir_y;
	assign dir[2] = in_word.dir_z;

	for (genvar a = 0; a < AXES; a++) begin : g_lane
		rbsi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk(clk), .en(en), .lower(lower_q[a]), .upper(upper_q[a]),
			.origin(org[a]), .dir(dir[a]), .slab(slab[a])
		);
	end

	rbsi_merge u_merge (.clk(clk), .en(en), .slab(slab), .res(out_word));

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.hit |-> !out_word.origin_inside &&
			out_word.near_dist == '0 && out_word.far_dist == '0)
		else $error("miss word carries nonzero fields");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.hit |-> out_word.near_dist <= out_word.far_dist)
		else $error("near distance beyond far distance");

	a_inside_far: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.origin_inside |-> out_word.far_dist == TMAX)
		else $error("inside word without saturated far distance");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("stalled result word changed");

endmodule

// File: dv/ray_box_slab_intersect_core_test.sv
`timescale 1ns / 100ps

module ray_box_slab_intersect_core_test;
	import rbsi_pkg::*;

	localparam longint DMAX = 64'd2147483647;

	// Predicted result words in acceptance order, checked against out_word.
	class slab_scoreboard;
		result_t pending_results[$];
		longint box_lo[3];
		longint box_hi[3];
		int mismatches;
		int checked;
		int hits;
		int insides;

		function new();
			for (int i = 0; i < 3; i++) begin
				box_lo[i] = 0;
				box_hi[i] = 0;
			end
			mismatches = 0;
			checked = 0;
			hits = 0;
			insides = 0;
		endfunction

		function void set_corner(logic [REG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
			if (idx < 3)
				box_lo[idx] = longint'($signed(val));
			else if (idx < 6)
				box_hi[idx - 3] = longint'($signed(val));
		endfunction

		// Quotient with FRAC_BITS_DEF fraction bits, truncated, saturated.
		function longint plane_distance(longint num, longint den);
			longint an, ad, q0, r, frac, q;
			bit neg;
			an = (num < 0) ? -num : num;
			ad = (den < 0) ? -den : den;
			neg = (num < 0) != (den < 0);
			q0 = an / ad;
			r = an % ad;
			frac = 0;
			if (q0 > (DMAX >> FRAC_BITS_DEF)) begin
				q = DMAX;
			end else begin
				for (int i = 0; i < FRAC_BITS_DEF; i++) begin
					r = r << 1;
					frac = frac << 1;
					if (r >= ad) begin
						r = r - ad;
						frac = frac | 1;
					end
				end
				q = (q0 << FRAC_BITS_DEF) | frac;
				if (q > DMAX)
					q = DMAX;
			end
			return neg ? -q : q;
		endfunction

		function void note_ray(ray_t ray);
			longint org[3], dir[3];
			longint t_near, t_far, a, b, lo, hi;
			bit hit, org_in, in_slab;
			result_t res;
			org[0] = ray.origin_x; org[1] = ray.origin_y; org[2] = ray.origin_z;
			dir[0] = ray.dir_x; dir[1] = ray.dir_y; dir[2] = ray.dir_z;
			t_near = 0;
			t_far = DMAX;
			hit = 1;
			org_in = 1;
			for (int i = 0; i < 3; i++) begin
				in_slab = (box_lo[i] <= org[i]) && (org[i] <= box_hi[i]);
				if (!in_slab)
					org_in = 0;
				if (hit) begin
					if (dir[i] == 0) begin
						if (!in_slab)
							hit = 0;
					end else begin
						a = plane_distance(box_lo[i] - org[i], dir[i]);
						b = plane_distance(box_hi[i] - org[i], dir[i]);
						lo = (a > b) ? b : a;
						hi = (a > b) ? a : b;
						if (lo > t_near)
							t_near = lo;
						if (hi < t_far)
							t_far = hi;
						if (t_near > t_far)
							hit = 0;
					end
				end
			end
			res = '0;
			if (hit) begin
				res.hit = 1'b1;
				res.origin_inside = org_in;
				res.near_dist = org_in ? t_far[DIST_W-1:0] : t_near[DIST_W-1:0];
				res.far_dist = org_in ? TMAX : t_far[DIST_W-1:0];
			end
			pending_results.push_back(res);
		endfunction

		function void check_result(result_t got);
			result_t exp_res;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result %h", got);
				return;
			end
			exp_res = pending_results.pop_front();
			checked++;
			if (exp_res.hit)
				hits++;
			if (exp_res.origin_inside)
				insides++;
			if (got.hit !== exp_res.hit || got.origin_inside !== exp_res.origin_inside ||
					got.near_dist !== exp_res.near_dist || got.far_dist !== exp_res.far_dist) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result %0d exp hit=%b in=%b near=%h far=%h got hit=%b in=%b near=%h far=%h",
						checked, exp_res.hit, exp_res.origin_inside, exp_res.near_dist,
						exp_res.far_dist, got.hit, got.origin_inside, got.near_dist, got.far_dist);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [REG_IDX_W-1:0] wr_idx = '0;
	logic [COORD_W-1:0] wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	ray_t in_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	result_t out_word;

	slab_scoreboard board;
	int stall_mode = 0;
	int rays_sent = 0;
	int box_settings = 0;

	always #5 clk = ~clk;

	ray_box_slab_intersect_core DUT (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
	);

	// Check every result word accepted at this edge, against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(out_word);
	end

	// Receiver back-pressure: its own pattern, changing mode now and then.
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 1) == 0);
			default: out_stall <= ($urandom_range(0, 9) != 0);
		endcase
	end

	// Write one box corner register; only called while the pipe is empty.
	task automatic write_corner(logic [REG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_idx <= idx;
		wr_data <= val;
		board.set_corner(idx, val);
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic load_box(logic [COORD_W-1:0] lx, logic [COORD_W-1:0] ly,
			logic [COORD_W-1:0] lz, logic [COORD_W-1:0] ux,
			logic [COORD_W-1:0] uy, logic [COORD_W-1:0] uz);
		write_corner(REG_LOWER_X, lx);
		write_corner(REG_LOWER_Y, ly);
		write_corner(REG_LOWER_Z, lz);
		write_corner(REG_UPPER_X, ux);
		write_corner(REG_UPPER_Y, uy);
		write_corner(REG_UPPER_Z, uz);
		box_settings++;
	endtask

	// Present one ray word and hold it until accepted; valid stays high if
	// the caller sends another right after.
	task automatic send_ray(ray_t ray);
		in_valid <= 1'b1;
		in_word <= ray;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_ray(ray);
		rays_sent++;
	endtask

	task automatic idle_cycles(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Wait for every prediction to come back, then past the pipe depth.
	task automatic drain_pipe();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending_results.size() != 0)
			@(posedge clk);
		repeat (CORE_LAT + 4) @(posedge clk);
	endtask

	function automatic logic [COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '0;
			3: return $urandom();
			4: return $urandom_range(0, 1) ? 32'h0000_0001 : 32'hFFFF_FFFF;
			default: return $signed($urandom_range(0, 32'h0014_0000)) - 32'sh000A_0000;
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] rand_dir();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 32'h8000_0000;
			2: return 32'h7FFF_FFFF;
			3: return $urandom();
			4: return $urandom_range(0, 1) ? 32'h0000_0001 : 32'hFFFF_FFFF;
			default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
		endcase
	endfunction

	// Mostly rays aimed near the box, with some full-range noise.
	function automatic ray_t rand_ray();
		ray_t r;
		if ($urandom_range(0, 3) == 0) begin
			r = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
		end else begin
			r.origin_x = rand_coord(); r.origin_y = rand_coord(); r.origin_z = rand_coord();
			r.dir_x = rand_dir(); r.dir_y = rand_dir(); r.dir_z = rand_dir();
		end
		return r;
	endfunction

	task automatic random_phase(int n);
		int burst;
		while (n > 0) begin
			burst = $urandom_range(1, 40);
			while (burst > 0 && n > 0) begin
				send_ray(rand_ray());
				burst--;
				n--;
			end
			if ($urandom_range(0, 2) != 0)
				idle_cycles($urandom_range(1, 8));
		end
	endtask

	localparam logic [COORD_W-1:0] ONE = 32'h0001_0000;
	localparam logic [COORD_W-1:0] NEG_ONE = 32'hFFFF_0000;

	initial begin
		ray_t r;
		board = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset box is a single point at the origin: touching cases.
		send_ray('{0, 0, 0, 0, 0, 0});
		send_ray('{ONE, 0, 0, NEG_ONE, 0, 0});
		drain_pipe();

		// Unit box, directed rays.
		load_box(NEG_ONE, NEG_ONE, NEG_ONE, ONE, ONE, ONE);
		send_ray('{0, 0, 0, ONE, ONE, ONE});                  // origin inside
		send_ray('{32'hFFFB_0000, 0, 0, ONE, 0, 0});           // plain entry along x
		send_ray('{32'hFFFB_0000, 0, 0, NEG_ONE, 0, 0});       // pointing away
		send_ray('{32'hFFFB_0000, 32'h0005_0000, 0, ONE, 0, 0}); // zero dir, outside slab
		send_ray('{32'hFFFB_0000, ONE, 0, ONE, 0, 0});         // zero dir, on slab face
		send_ray('{32'hFFFB_0000, 32'hFFFB_0000, 0, ONE, ONE, 0}); // diagonal entry at an edge
		send_ray('{0, 0, 0, 0, 0, 0});                         // zero direction, inside
		send_ray('{32'h8000_0000, 0, 0, 32'h0000_0001, 0, 0}); // saturated distance
		send_ray('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
		send_ray('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
		send_ray('{ONE, ONE, ONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
		drain_pipe();

		// Inverted box on x, full-range box, then random boxes.
		load_box(ONE, NEG_ONE, NEG_ONE, NEG_ONE, ONE, ONE);
		send_ray('{32'hFFFB_0000, 0, 0, ONE, 0, 0});
		send_ray('{0, 0, 0, 0, ONE, 0});
		drain_pipe();
		load_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_ray('{32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h0000_0001, 32'hFFFF_FFFF, 0});
		random_phase(150);
		drain_pipe();

		for (int p = 0; p < 6; p++) begin
			logic [COORD_W-1:0] a, b;
			logic [COORD_W-1:0] c[6];
			for (int k = 0; k < 3; k++) begin
				a = rand_coord();
				b = rand_coord();
				// Keep most boxes well ordered; allow an inverted axis now and then.
				if ($signed(a) > $signed(b) && $urandom_range(0, 4) != 0) begin
					c[k] = b; c[k+3] = a;
				end else begin
					c[k] = a; c[k+3] = b;
				end
			end
			load_box(c[0], c[1], c[2], c[3], c[4], c[5]);
			random_phase(190);
			drain_pipe();
		end

		$display("Covered %0d rays over %0d box settings: %0d hits, %0d with origin inside",
			rays_sent, box_settings, board.hits, board.insides);
		$display("Results checked: %0d, mismatches: %0d", board.checked, board.mismatches);
		if (board.mismatches == 0 && board.pending_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timeout waiting for results");
		$display("Regression FAIL");
		$finish;
	end

endmodule

// File: filelist.f
rtl/rbsi_pkg.sv
rtl/rbsi_div.sv
rtl/rbsi_lane.sv
rtl/rbsi_merge.sv
rtl/ray_box_slab_intersect_core.sv
dv/ray_box_slab_intersect_core_test.sv
